### sv/mpeg_program_stream_demux_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the program stream demultiplexer
// Concurrent checks that drop out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MPEG_PROGRAM_STREAM_DEMUX_MACROS_SVH
`define MPEG_PROGRAM_STREAM_DEMUX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MPSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mpsd assertion failed");
`define MPSD_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mpsd assertion failed");
`else
`define MPSD_ASSERT(lbl, clk, rstn, prop)
`define MPSD_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

### sv/mpsd_pkg.sv
// ----------------------------------------------------------------------------
// mpsd_pkg
// Types and codes shared by the program stream demultiplexer.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  typedef enum logic [4:0] {
    PH_SEARCH, PH_CODE, PH_PACK_FIRST, PH_PACK2, PH_SKIP_HI, PH_SKIP_LO,
    PH_SKIP, PH_PES_HI, PH_PES_LO, PH_PES_FIRST, PH_M2_FLAGS, PH_M2_HDL,
    PH_M1_STUFF, PH_M1_STD, PH_M1_MARK, PH_REGION, PH_PAYLOAD
  } phase_e;

  typedef enum logic [2:0] {
    KIND_VIDEO = 3'd0,
    KIND_AUDIO = 3'd1,
    KIND_PTS   = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_PACK      = 3'd1,
    ERR_PES_LEN   = 3'd2,
    ERR_PES_HDR   = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  localparam logic [23:0] StartInit = 24'hffffff;
  localparam logic [23:0] StartCode = 24'h000001;
  localparam logic [7:0]  CodeEnd   = 8'hb9;
  localparam logic [7:0]  CodePack  = 8'hba;
  localparam logic [7:0]  M1NoPts   = 8'h0f;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [32:0] pts_value;
    err_e        error_code;
  } result_t;

endpackage

### sv/mpsd_if.sv
// ----------------------------------------------------------------------------
// mpsd_in_if / mpsd_out_if
// Valid/ready channels for stream bytes and demultiplexed results.
// ----------------------------------------------------------------------------
interface mpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;
  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

interface mpsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [32:0] pts_value;
  logic [2:0]  error_code;
  modport source (output valid, output kind, output out_byte, output pts_value,
                  output error_code, input ready);
  modport sink (input valid, input kind, input out_byte, input pts_value,
                input error_code, output ready);
endinterface

### sv/mpsd_parser.sv
// ----------------------------------------------------------------------------
// mpsd_parser
// Parse state machine: start code hunt, pack and PES headers, stream locks.
// ----------------------------------------------------------------------------
`include "mpeg_program_stream_demux_macros.svh"

module mpsd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_final_i,
  output mpsd_pkg::result_t result_o
);

  mpsd_pkg::phase_e phase_q, phase_d;
  logic [23:0] shift_q, shift_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  hc_q, hc_d;
  logic [7:0]  hdl_q, hdl_d;
  logic [32:0] pts_q, pts_d;
  logic        pp_q, pp_d;
  logic [8:0]  vlock_q, vlock_d;
  logic [8:0]  alock_q, alock_d;
  logic        halt_q, halt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpsd_pkg::PH_SEARCH;
      shift_q <= mpsd_pkg::StartInit;
      code_q  <= '0;
      rem_q   <= '0;
      hc_q    <= '0;
      hdl_q   <= '0;
      pts_q   <= '0;
      pp_q    <= 1'b0;
      vlock_q <= '0;
      alock_q <= '0;
      halt_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      hc_q    <= hc_d;
      hdl_q   <= hdl_d;
      pts_q   <= pts_d;
      pp_q    <= pp_d;
      vlock_q <= vlock_d;
      alock_q <= alock_d;
      halt_q  <= halt_d;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] rem_m1;
    logic [7:0]  hc_p1;
    logic        video;
    logic        fail;
    logic        done;
    logic [15:0] m1_len;
    logic [8:0]  lock;
    mpsd_pkg::err_e ecode;
    b       = data_byte_i;
    rem_m1  = rem_q - 16'd1;
    hc_p1   = hc_q + 8'd1;
    video   = (code_q[7:4] == 4'he);
    fail    = 1'b0;
    done    = 1'b0;
    ecode   = mpsd_pkg::ERR_PES_HDR;
    m1_len  = (b[4]) ? 16'd10 : 16'd5;
    lock    = '0;
    phase_d = phase_q;
    shift_d = shift_q;
    code_d  = code_q;
    rem_d   = rem_q;
    hc_d    = hc_q;
    hdl_d   = hdl_q;
    pts_d   = pts_q;
    pp_d    = pp_q;
    vlock_d = vlock_q;
    alock_d = alock_q;
    halt_d  = halt_q;
    result_o = '{valid: 1'b0, kind: mpsd_pkg::KIND_VIDEO, out_byte: 8'd0,
                 pts_value: 33'd0, error_code: mpsd_pkg::ERR_NONE};

    if (!halt_q) begin
      unique case (phase_q)
        mpsd_pkg::PH_SEARCH: begin
          shift_d = {shift_q[15:0], b};
          if (shift_d == mpsd_pkg::StartCode) phase_d = mpsd_pkg::PH_CODE;
        end
        mpsd_pkg::PH_CODE: begin
          code_d = b;
          if (b == mpsd_pkg::CodeEnd) begin
            done = 1'b1;
            result_o.valid = 1'b1;
            result_o.kind  = mpsd_pkg::KIND_END;
          end else if (b == mpsd_pkg::CodePack) begin
            phase_d = mpsd_pkg::PH_PACK_FIRST;
          end else if (b[7:4] == 4'he || b[7:5] == 3'b110) begin
            phase_d = mpsd_pkg::PH_PES_HI;
          end else begin
            phase_d = mpsd_pkg::PH_SKIP_HI;
          end
        end
        mpsd_pkg::PH_PACK_FIRST: begin
          if (b[7:6] == 2'b01) begin
            rem_d = 16'd9;
            phase_d = mpsd_pkg::PH_PACK2;
          end else if (b[7:4] == 4'h2) begin
            rem_d = 16'd7;
            phase_d = mpsd_pkg::PH_SKIP;
          end else begin
            fail = 1'b1;
            ecode = mpsd_pkg::ERR_PACK;
          end
        end
        mpsd_pkg::PH_PACK2: begin
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) begin
            rem_d = {13'd0, b[2:0]};
            phase_d = (b[2:0] == 3'd0) ? mpsd_pkg::PH_SEARCH : mpsd_pkg::PH_SKIP;
          end
        end
        mpsd_pkg::PH_SKIP_HI: begin
          rem_d = {b, 8'd0};
          phase_d = mpsd_pkg::PH_SKIP_LO;
        end
        mpsd_pkg::PH_PES_HI: begin
          rem_d = {b, 8'd0};
          phase_d = mpsd_pkg::PH_PES_LO;
        end
        mpsd_pkg::PH_SKIP_LO: begin
          rem_d = {rem_q[15:8], b};
          phase_d = (rem_d == 16'd0) ? mpsd_pkg::PH_SEARCH : mpsd_pkg::PH_SKIP;
        end
        mpsd_pkg::PH_SKIP: begin
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) phase_d = mpsd_pkg::PH_SEARCH;
        end
        mpsd_pkg::PH_PES_LO: begin
          rem_d = {rem_q[15:8], b};
          if (rem_d == 16'd0) begin
            fail = 1'b1;
            ecode = mpsd_pkg::ERR_PES_LEN;
          end else begin
            lock = video ? vlock_q : alock_q;
            if (!lock[8]) lock = {1'b1, code_q};
            if (video) vlock_d = lock;
            else alock_d = lock;
            pts_d = '0;
            pp_d  = 1'b0;
            hc_d  = '0;
            hdl_d = '0;
            phase_d = (lock[7:0] == code_q) ? mpsd_pkg::PH_PES_FIRST
                                            : mpsd_pkg::PH_SKIP;
          end
        end
        mpsd_pkg::PH_PES_FIRST, mpsd_pkg::PH_M1_STUFF, mpsd_pkg::PH_M1_MARK: begin
          if (phase_q == mpsd_pkg::PH_PES_FIRST && b[7:6] == 2'b10) begin
            if (rem_q < 16'd3) fail = 1'b1;
            rem_d = rem_m1;
            phase_d = mpsd_pkg::PH_M2_FLAGS;
          end else if (phase_q != mpsd_pkg::PH_M1_MARK && b == 8'hff) begin
            if (rem_q <= 16'd1) fail = 1'b1;
            rem_d = rem_m1;
            phase_d = mpsd_pkg::PH_M1_STUFF;
          end else if (phase_q != mpsd_pkg::PH_M1_MARK && b[7:6] == 2'b01) begin
            if (rem_q <= 16'd2) fail = 1'b1;
            rem_d = rem_m1;
            phase_d = mpsd_pkg::PH_M1_STD;
          end else if (b[7:5] == 3'b001) begin
            if (rem_q < m1_len) fail = 1'b1;
            hdl_d = m1_len[7:0];
            hc_d  = 8'd1;
            pp_d  = 1'b1;
            pts_d = {b[3:1], 30'd0};
            rem_d = rem_m1;
            phase_d = mpsd_pkg::PH_REGION;
          end else if (b == mpsd_pkg::M1NoPts) begin
            rem_d = rem_m1;
            phase_d = (rem_m1 == 16'd0) ? mpsd_pkg::PH_SEARCH : mpsd_pkg::PH_PAYLOAD;
          end else begin
            fail = 1'b1;
          end
        end
        mpsd_pkg::PH_M2_FLAGS: begin
          pp_d = b[7];
          rem_d = rem_m1;
          phase_d = mpsd_pkg::PH_M2_HDL;
        end
        mpsd_pkg::PH_M2_HDL: begin
          if ({8'd0, b} >= rem_q || (pp_q && b < 8'd5)) fail = 1'b1;
          hdl_d = b;
          hc_d  = '0;
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) phase_d = mpsd_pkg::PH_SEARCH;
          else phase_d = (b == 8'd0) ? mpsd_pkg::PH_PAYLOAD : mpsd_pkg::PH_REGION;
        end
        mpsd_pkg::PH_M1_STD: begin
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) fail = 1'b1;
          phase_d = mpsd_pkg::PH_M1_MARK;
        end
        mpsd_pkg::PH_REGION: begin
          if (pp_q) begin
            unique case (hc_q)
              8'd0: pts_d = {b[3:1], 30'd0};
              8'd1: pts_d = pts_q | {3'd0, b, 22'd0};
              8'd2: pts_d = pts_q | {11'd0, b[7:1], 15'd0};
              8'd3: pts_d = pts_q | {18'd0, b, 7'd0};
              8'd4: begin
                pts_d = pts_q | {26'd0, b[7:1]};
                if (video) begin
                  result_o.valid = 1'b1;
                  result_o.kind = mpsd_pkg::KIND_PTS;
                  result_o.pts_value = pts_d;
                end
              end
              default: pts_d = pts_q;
            endcase
          end
          hc_d  = hc_p1;
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) phase_d = mpsd_pkg::PH_SEARCH;
          else if (hc_p1 >= hdl_q) phase_d = mpsd_pkg::PH_PAYLOAD;
          else phase_d = mpsd_pkg::PH_REGION;
        end
        mpsd_pkg::PH_PAYLOAD: begin
          result_o.valid = 1'b1;
          result_o.kind = video ? mpsd_pkg::KIND_VIDEO : mpsd_pkg::KIND_AUDIO;
          result_o.out_byte = b;
          rem_d = rem_m1;
          if (rem_m1 == 16'd0) phase_d = mpsd_pkg::PH_SEARCH;
        end
        default: phase_d = mpsd_pkg::PH_SEARCH;
      endcase

      if (phase_d == mpsd_pkg::PH_SEARCH && phase_q != mpsd_pkg::PH_SEARCH) begin
        shift_d = mpsd_pkg::StartInit;
      end

      if (fail) begin
        halt_d = 1'b1;
        result_o = '{valid: 1'b1, kind: mpsd_pkg::KIND_ERROR, out_byte: 8'd0,
                     pts_value: 33'd0, error_code: ecode};
      end else if (done) begin
        halt_d = 1'b1;
      end else if (is_final_i) begin
        halt_d = 1'b1;
        if (phase_d != mpsd_pkg::PH_SEARCH) begin
          result_o = '{valid: 1'b1, kind: mpsd_pkg::KIND_ERROR, out_byte: 8'd0,
                       pts_value: 33'd0, error_code: mpsd_pkg::ERR_TRUNCATED};
        end else if (!result_o.valid) begin
          result_o.valid = 1'b1;
          result_o.kind = mpsd_pkg::KIND_END;
        end
      end
    end
  end

  `MPSD_ASSERT(a_halt_quiet, clk_i, rst_ni, halt_q |-> !result_o.valid)
  `MPSD_ASSERT(a_err_code, clk_i, rst_ni,
    (result_o.valid && result_o.kind == mpsd_pkg::KIND_ERROR) |->
      result_o.error_code != mpsd_pkg::ERR_NONE)
  `MPSD_ASSERT(a_payload_len, clk_i, rst_ni,
    (!halt_q && phase_q == mpsd_pkg::PH_PAYLOAD) |-> rem_q != 16'd0)
  `MPSD_ASSERT(a_halt_sticky, clk_i, rst_ni, halt_q |=> halt_q)

endmodule

### sv/mpeg_program_stream_demux.sv
// ----------------------------------------------------------------------------
// mpeg_program_stream_demux
// Takes one program stream byte per transaction and gives at most one result
// per byte: a video or audio payload byte of the first locked streams, a video
// PTS, an end marker or a sticky error. Each byte is parsed in the cycle it is
// taken and its result lands in a single output register, so a byte is taken
// every cycle while that register is empty or being drained, and a result shows
// on the output in the cycle after its byte is taken. After an end marker or
// error the block takes bytes but gives nothing until reset.
// ----------------------------------------------------------------------------
`include "mpeg_program_stream_demux_macros.svh"

module mpeg_program_stream_demux (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpsd_in_if.sink      in_i,
  mpsd_out_if.source   out_o
);

  mpsd_pkg::result_t res;
  mpsd_pkg::result_t out_q;
  logic              out_valid_q;
  logic              step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step = in_i.valid && in_i.ready;

  mpsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_i.data_byte),
    .is_final_i  (in_i.is_final),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.pts_value  = out_q.pts_value;
  assign out_o.error_code = out_q.error_code;

  `MPSD_ASSERT(a_load, clk_i, rst_ni, (step && res.valid) |=> out_valid_q)
  `MPSD_ASSERT(a_stall_hold, clk_i, rst_ni,
    (out_valid_q && !out_o.ready) |-> !step)
  `MPSD_ASSERT(a_pts_zero, clk_i, rst_ni,
    (out_valid_q && out_o.kind != mpsd_pkg::KIND_PTS) |-> out_o.pts_value == 33'd0)

endmodule

### verif/mpsd_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpsd_result_checker
// Watches both channels of the program stream demultiplexer. Every accepted
// byte runs through a local parser that keeps its own copy of the parse
// state and queues the result that byte should cause; every accepted result
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module mpsd_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mpsd_in_if   in_ch,
  mpsd_out_if  out_ch,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct {
    mpsd_pkg::kind_e kind;
    logic [7:0]      out_byte;
    logic [32:0]     pts_value;
    mpsd_pkg::err_e  error_code;
  } demux_result_t;

  demux_result_t expected_q[$];

  logic [23:0]      shift_q;
  mpsd_pkg::phase_e phase_q;
  logic [7:0]       code_q;
  logic [15:0]      rem_q;
  logic [7:0]       hdr_cnt_q;
  logic [7:0]       hdr_len_q;
  logic [32:0]      pts_acc_q;
  logic             pts_on_q;
  logic [8:0]       video_lock_q;
  logic [8:0]       audio_lock_q;
  logic             halted_q;

  logic          have_res;
  demux_result_t res;

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
    shift_q      = mpsd_pkg::StartInit;
    phase_q      = mpsd_pkg::PH_SEARCH;
    code_q       = '0;
    rem_q        = '0;
    hdr_cnt_q    = '0;
    hdr_len_q    = '0;
    pts_acc_q    = '0;
    pts_on_q     = 1'b0;
    video_lock_q = '0;
    audio_lock_q = '0;
    halted_q     = 1'b0;
  end

  function automatic logic code_is_video();
    return code_q[7:4] == 4'he;
  endfunction

  task automatic emit(mpsd_pkg::kind_e k, logic [7:0] b, logic [32:0] p,
                      mpsd_pkg::err_e e);
    have_res = 1'b1;
    res.kind = k;
    res.out_byte = b;
    res.pts_value = p;
    res.error_code = e;
  endtask

  task automatic halt_with(mpsd_pkg::err_e e);
    halted_q = 1'b1;
    emit(mpsd_pkg::KIND_ERROR, 8'd0, 33'd0, e);
  endtask

  task automatic restart_search();
    phase_q = mpsd_pkg::PH_SEARCH;
    shift_q = mpsd_pkg::StartInit;
  endtask

  task automatic region_byte(logic [7:0] b);
    if (pts_on_q) begin
      case (hdr_cnt_q)
        8'd0: pts_acc_q = {b[3:1], 30'd0};
        8'd1: pts_acc_q = pts_acc_q | (33'(b) << 22);
        8'd2: pts_acc_q = pts_acc_q | (33'(b[7:1]) << 15);
        8'd3: pts_acc_q = pts_acc_q | (33'(b) << 7);
        8'd4: begin
          pts_acc_q = pts_acc_q | 33'(b[7:1]);
          if (code_is_video()) begin
            emit(mpsd_pkg::KIND_PTS, 8'd0, pts_acc_q, mpsd_pkg::ERR_NONE);
          end
        end
        default: ;
      endcase
    end
    hdr_cnt_q = hdr_cnt_q + 8'd1;
    rem_q = rem_q - 16'd1;
    if (rem_q == 16'd0) restart_search();
    else if (hdr_cnt_q >= hdr_len_q) phase_q = mpsd_pkg::PH_PAYLOAD;
    else phase_q = mpsd_pkg::PH_REGION;
  endtask

  task automatic m1_marker(logic [7:0] b);
    logic [15:0] need;
    if (b[7:4] == 4'h2 || b[7:4] == 4'h3) begin
      need = (b[7:4] == 4'h2) ? 16'd5 : 16'd10;
      if (rem_q < need) begin
        halt_with(mpsd_pkg::ERR_PES_HDR);
      end else begin
        hdr_len_q = need[7:0];
        hdr_cnt_q = 8'd0;
        pts_on_q = 1'b1;
        region_byte(b);
      end
    end else if (b == mpsd_pkg::M1NoPts) begin
      rem_q = rem_q - 16'd1;
      if (rem_q == 16'd0) restart_search();
      else phase_q = mpsd_pkg::PH_PAYLOAD;
    end else begin
      halt_with(mpsd_pkg::ERR_PES_HDR);
    end
  endtask

  task automatic m1_byte(logic [7:0] b);
    if (b == 8'hff) begin
      if (rem_q <= 16'd1) halt_with(mpsd_pkg::ERR_PES_HDR);
      else begin
        rem_q = rem_q - 16'd1;
        phase_q = mpsd_pkg::PH_M1_STUFF;
      end
    end else if (b[7:6] == 2'b01) begin
      if (rem_q <= 16'd2) halt_with(mpsd_pkg::ERR_PES_HDR);
      else begin
        rem_q = rem_q - 16'd1;
        phase_q = mpsd_pkg::PH_M1_STD;
      end
    end else begin
      m1_marker(b);
    end
  endtask

  task automatic parse_byte(logic [7:0] b, logic fin);
    logic [8:0] lock;
    have_res = 1'b0;
    if (halted_q) return;
    case (phase_q)
      mpsd_pkg::PH_SEARCH: begin
        shift_q = {shift_q[15:0], b};
        if (shift_q == mpsd_pkg::StartCode) phase_q = mpsd_pkg::PH_CODE;
      end
      mpsd_pkg::PH_CODE: begin
        code_q = b;
        if (b == mpsd_pkg::CodeEnd) begin
          halted_q = 1'b1;
          emit(mpsd_pkg::KIND_END, 8'd0, 33'd0, mpsd_pkg::ERR_NONE);
        end else if (b == mpsd_pkg::CodePack) phase_q = mpsd_pkg::PH_PACK_FIRST;
        else if (b[7:4] == 4'he || b[7:5] == 3'b110) phase_q = mpsd_pkg::PH_PES_HI;
        else phase_q = mpsd_pkg::PH_SKIP_HI;
      end
      mpsd_pkg::PH_PACK_FIRST: begin
        if (b[7:6] == 2'b01) begin
          rem_q = 16'd9;
          phase_q = mpsd_pkg::PH_PACK2;
        end else if (b[7:4] == 4'h2) begin
          rem_q = 16'd7;
          phase_q = mpsd_pkg::PH_SKIP;
        end else halt_with(mpsd_pkg::ERR_PACK);
      end
      mpsd_pkg::PH_PACK2: begin
        rem_q = rem_q - 16'd1;
        if (rem_q == 16'd0) begin
          rem_q = {13'd0, b[2:0]};
          if (rem_q == 16'd0) restart_search();
          else phase_q = mpsd_pkg::PH_SKIP;
        end
      end
      mpsd_pkg::PH_SKIP_HI, mpsd_pkg::PH_PES_HI: begin
        rem_q = {b, 8'd0};
        phase_q = (phase_q == mpsd_pkg::PH_SKIP_HI) ? mpsd_pkg::PH_SKIP_LO
                                                     : mpsd_pkg::PH_PES_LO;
      end
      mpsd_pkg::PH_SKIP_LO: begin
        rem_q[7:0] = b;
        if (rem_q == 16'd0) restart_search();
        else phase_q = mpsd_pkg::PH_SKIP;
      end
      mpsd_pkg::PH_SKIP: begin
        rem_q = rem_q - 16'd1;
        if (rem_q == 16'd0) restart_search();
      end
      mpsd_pkg::PH_PES_LO: begin
        rem_q[7:0] = b;
        if (rem_q == 16'd0) halt_with(mpsd_pkg::ERR_PES_LEN);
        else begin
          lock = code_is_video() ? video_lock_q : audio_lock_q;
          if (!lock[8]) lock = {1'b1, code_q};
          if (code_is_video()) video_lock_q = lock;
          else audio_lock_q = lock;
          pts_acc_q = '0;
          pts_on_q = 1'b0;
          hdr_cnt_q = '0;
          hdr_len_q = '0;
          phase_q = (lock[7:0] == code_q) ? mpsd_pkg::PH_PES_FIRST : mpsd_pkg::PH_SKIP;
        end
      end
      mpsd_pkg::PH_PES_FIRST: begin
        if (b[7:6] == 2'b10) begin
          if (rem_q < 16'd3) halt_with(mpsd_pkg::ERR_PES_HDR);
          else begin
            rem_q = rem_q - 16'd1;
            phase_q = mpsd_pkg::PH_M2_FLAGS;
          end
        end else m1_byte(b);
      end
      mpsd_pkg::PH_M2_FLAGS: begin
        pts_on_q = b[7];
        rem_q = rem_q - 16'd1;
        phase_q = mpsd_pkg::PH_M2_HDL;
      end
      mpsd_pkg::PH_M2_HDL: begin
        if (16'(b) >= rem_q || (pts_on_q && b < 8'd5)) halt_with(mpsd_pkg::ERR_PES_HDR);
        else begin
          hdr_len_q = b;
          hdr_cnt_q = 8'd0;
          rem_q = rem_q - 16'd1;
          if (rem_q == 16'd0) restart_search();
          else phase_q = (b == 8'd0) ? mpsd_pkg::PH_PAYLOAD : mpsd_pkg::PH_REGION;
        end
      end
      mpsd_pkg::PH_M1_STUFF: m1_byte(b);
      mpsd_pkg::PH_M1_STD: begin
        rem_q = rem_q - 16'd1;
        if (rem_q == 16'd0) halt_with(mpsd_pkg::ERR_PES_HDR);
        else phase_q = mpsd_pkg::PH_M1_MARK;
      end
      mpsd_pkg::PH_M1_MARK: m1_marker(b);
      mpsd_pkg::PH_REGION: region_byte(b);
      mpsd_pkg::PH_PAYLOAD: begin
        emit(code_is_video() ? mpsd_pkg::KIND_VIDEO : mpsd_pkg::KIND_AUDIO, b, 33'd0,
             mpsd_pkg::ERR_NONE);
        rem_q = rem_q - 16'd1;
        if (rem_q == 16'd0) restart_search();
      end
      default: restart_search();
    endcase
    if (fin && !halted_q) begin
      if (phase_q == mpsd_pkg::PH_SEARCH) begin
        halted_q = 1'b1;
        if (!have_res) emit(mpsd_pkg::KIND_END, 8'd0, 33'd0, mpsd_pkg::ERR_NONE);
      end else begin
        halt_with(mpsd_pkg::ERR_TRUNCATED);
      end
    end
  endtask

  always @(posedge clk_i) begin
    demux_result_t exp_r;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result kind %0d byte %0h pts %0h err %0d", $time,
                   out_ch.kind, out_ch.out_byte, out_ch.pts_value, out_ch.error_code);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.kind !== exp_r.kind || out_ch.out_byte !== exp_r.out_byte ||
              out_ch.pts_value !== exp_r.pts_value ||
              out_ch.error_code !== exp_r.error_code) begin
            errors_o++;
            $display("%0t: expected kind %0d byte %0h pts %0h err %0d", $time,
                     exp_r.kind, exp_r.out_byte, exp_r.pts_value, exp_r.error_code);
            $display("%0t:   actual kind %0d byte %0h pts %0h err %0d", $time,
                     out_ch.kind, out_ch.out_byte, out_ch.pts_value, out_ch.error_code);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, in_ch.is_final);
        if (have_res) expected_q.push_back(res);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the demultiplexer one program stream built of pack headers, skipped
// packets, kept and dropped PES packets in both header forms and noise,
// closed by one randomly chosen terminator, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Limit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mpsd_in_if  in_if ();
  mpsd_out_if out_if ();

  int errors, pending, checked;
  int cycle_cnt = 0;
  int sent = 0;
  logic in_fire = 1'b0;
  logic [8:0] stream_q[$];
  logic [7:0] vid_code, aud_code;

  mpeg_program_stream_demux u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mpsd_result_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    in_fire <= in_if.valid && in_if.ready;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("mpeg_program_stream_demux: mismatch");
      $finish;
    end
  end

  task automatic put_byte(logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endtask

  task automatic put_start(logic [7:0] code);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte(code);
  endtask

  task automatic put_noise();
    int n;
    n = $urandom_range(0, 4);
    repeat (n) put_byte(8'($urandom_range(1, 255)));
  endtask

  task automatic put_pack(int mpeg2, int stuff);
    put_start(mpsd_pkg::CodePack);
    if (mpeg2) begin
      put_byte({2'b01, 6'($urandom)});
      repeat (8) put_byte(8'($urandom));
      put_byte({5'($urandom), 3'(stuff)});
      repeat (stuff) put_byte(8'($urandom));
    end else begin
      put_byte({4'h2, 4'($urandom)});
      repeat (7) put_byte(8'($urandom));
    end
  endtask

  task automatic put_skipped(int len);
    logic [7:0] code;
    case ($urandom_range(0, 2))
      0: code = 8'($urandom_range(0, 8'hb8));
      1: code = 8'($urandom_range(8'hbb, 8'hbf));
      default: code = 8'($urandom_range(8'hf0, 8'hff));
    endcase
    put_start(code);
    put_byte(8'(len >> 8));
    put_byte(8'(len));
    repeat (len) put_byte(8'($urandom));
  endtask

  // mode: 0 MPEG-2 with PTS, 1 MPEG-2 without, 2 MPEG-1 PTS, 3 MPEG-1 PTS+DTS,
  // 4 MPEG-1 without timestamp
  task automatic put_pes(logic [7:0] code, int mode, int min_pay, int max_pay);
    logic [7:0] body[$];
    int hdl, pay;
    pay = $urandom_range(min_pay, max_pay);
    if (mode <= 1) begin
      hdl = (mode == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
      body.push_back({2'b10, 6'($urandom)});
      body.push_back({(mode == 0) ? 1'b1 : 1'b0, 7'($urandom)});
      body.push_back(8'(hdl));
      repeat (hdl) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) body.push_back(8'hff);
      if ($urandom_range(0, 1)) begin
        body.push_back({2'b01, 6'($urandom)});
        body.push_back(8'($urandom));
      end
      if (mode == 4) body.push_back(mpsd_pkg::M1NoPts);
      else begin
        body.push_back({(mode == 2) ? 4'h2 : 4'h3, 4'($urandom)});
        repeat ((mode == 2) ? 4 : 9) body.push_back(8'($urandom));
      end
    end
    repeat (pay) body.push_back(8'($urandom));
    put_start(code);
    put_byte(8'(body.size() >> 8));
    put_byte(8'(body.size()));
    foreach (body[i]) put_byte(body[i]);
  endtask

  task automatic put_random_packet();
    int r, big;
    r = $urandom_range(0, 99);
    big = ($urandom_range(0, 19) == 0) ? 160 : 20;
    put_noise();
    if (r < 10) put_pack($urandom_range(0, 1), $urandom_range(0, 7));
    else if (r < 18) put_skipped($urandom_range(0, 12));
    else if (r < 55) put_pes(vid_code, $urandom_range(0, 4), 0, big);
    else if (r < 88) put_pes(aud_code, $urandom_range(0, 4), 0, big);
    else if (r < 94) put_pes({4'he, vid_code[3:0] ^ 4'($urandom_range(1, 15))},
                             $urandom_range(0, 4), 0, 20);
    else put_pes(8'($urandom_range(8'hc0, 8'hdf)), $urandom_range(0, 4), 0, 20);
  endtask

  task automatic put_terminator();
    int n0, cut;
    n0 = stream_q.size();
    case ($urandom_range(0, 6))
      0: put_start(mpsd_pkg::CodeEnd);
      1: begin
        put_byte(8'($urandom_range(1, 255)));
        stream_q[$][8] = 1'b1;
      end
      2: begin
        put_pes(vid_code, $urandom_range(0, 4), 1, 20);
        stream_q[$][8] = 1'b1;
      end
      3: begin
        put_pes(vid_code, 0, 2, 20);
        cut = $urandom_range(n0 + 4, stream_q.size() - 2);
        while (stream_q.size() > cut + 1) void'(stream_q.pop_back());
        stream_q[$][8] = 1'b1;
      end
      4: begin
        put_start(mpsd_pkg::CodePack);
        put_byte(8'($urandom_range(0, 31)));
      end
      5: begin
        put_start(aud_code);
        put_byte(8'h00);
        put_byte(8'h00);
      end
      default: begin
        put_start(vid_code);
        put_byte(8'h00);
        put_byte(8'h05);
        put_byte(8'h10);
      end
    endcase
    repeat (6) stream_q.push_back(9'($urandom));
  endtask

  initial begin
    vid_code = 8'($urandom_range(8'he0, 8'hef));
    aud_code = 8'($urandom_range(8'hc0, 8'hdf));
    put_pack(0, 0);
    put_pack(1, 7);
    put_pack(1, 0);
    put_skipped(0);
    put_pes(vid_code, 0, 2, 4);
    put_pes(aud_code, 3, 2, 4);
    put_pes(aud_code, 2, 0, 0);
    put_pes(vid_code, 4, 1, 3);
    put_pes(vid_code, 1, 0, 2);
    put_pes({4'he, ~vid_code[3:0]}, 0, 1, 3);
    put_pes(aud_code ^ 8'h01, 2, 1, 3);
    while (stream_q.size() < 1750) put_random_packet();
    put_terminator();
  end

  // sender
  initial begin
    int idx;
    idx = 0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.is_final = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    while (idx < stream_q.size()) begin
      @(negedge clk_i);
      if (in_fire) idx++;
      if (in_if.valid && !in_fire) continue;
      if (idx >= stream_q.size()) begin
        in_if.valid = 1'b0;
      end else if (idx == 900 && in_fire) begin
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end else if ((idx < 400 || idx > 700) && $urandom_range(0, 99) < 31) begin
        in_if.valid = 1'b0;
      end else begin
        in_if.valid = 1'b1;
        {in_if.is_final, in_if.data_byte} = stream_q[idx];
      end
    end
    sent = idx;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("sent %0d stream bytes (packs, skips, kept and dropped PES), checked %0d results",
             sent, checked);
    if (errors == 0) $display("mpeg_program_stream_demux: match");
    else $display("mpeg_program_stream_demux: mismatch");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stall-free stretch
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cycle_cnt >= 1500 && hold_cnt < 300) begin
        hold_cnt++;
        out_if.ready = 1'b0;
      end else if (cycle_cnt >= 2000 && cycle_cnt < 2600) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= 31);
      end
    end
  end

endmodule

### mpeg_program_stream_demux.f
+incdir+sv
sv/mpsd_pkg.sv
sv/mpsd_if.sv
sv/mpsd_parser.sv
sv/mpeg_program_stream_demux.sv
verif/mpsd_result_checker.sv
verif/tb_top.sv
